// ===== rtl/core/ile_pkg.sv =====
package ile_pkg;

  localparam int REQ_W        = 4;
  localparam int IDX_W        = 5;
  localparam int VAL_W        = 32;
  localparam int CNT_OUT_W    = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND       = 4'd0,
    REQ_PREPEND      = 4'd1,
    REQ_INSERT       = 4'd2,
    REQ_REMOVE_LAST  = 4'd3,
    REQ_REMOVE_FIRST = 4'd4,
    REQ_DELETE       = 4'd5,
    REQ_GET          = 4'd6,
    REQ_SET          = 4'd7,
    REQ_REVERSE      = 4'd8
  } req_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_SET,
    CELL_RD_LOAD,
    CELL_RD_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  value;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

// ===== rtl/core/ile_if.sv =====
interface ile_req_if;
  logic                                valid;
  logic                                ready;
  logic [ile_pkg::REQ_W-1:0]           req_type;
  logic [ile_pkg::IDX_W-1:0]           index;
  logic signed [ile_pkg::VAL_W-1:0]    value;

  modport source (output valid, req_type, index, value, input ready);
  modport sink   (input valid, req_type, index, value, output ready);
endinterface

interface ile_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [ile_pkg::VAL_W-1:0]    read_value;
  logic [ile_pkg::CNT_OUT_W-1:0]       count;

  modport source (output valid, ok, read_value, count, input ready);
  modport sink   (input valid, ok, read_value, count, output ready);
endinterface

// ===== rtl/core/ile_cell.sv =====
module ile_cell #(
  parameter int POS_W = 4,
  parameter int J     = 0
) (
  input  logic                         clk,
  input  ile_pkg::cell_ctl_t           ctl,
  input  logic [POS_W-1:0]             pos,
  input  logic [ile_pkg::VAL_W-1:0]    left_data,
  input  logic [ile_pkg::VAL_W-1:0]    right_data,
  input  logic [ile_pkg::VAL_W-1:0]    right_rd,
  output logic [ile_pkg::VAL_W-1:0]    data_o,
  output logic [ile_pkg::VAL_W-1:0]    rd_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(J);

  logic [ile_pkg::VAL_W-1:0] data_r, data_nxt;
  logic [ile_pkg::VAL_W-1:0] rd_r, rd_nxt;

  always_comb begin
    data_nxt = data_r;
    rd_nxt   = rd_r;
    case (ctl.op)
      ile_pkg::CELL_INS: begin
        // cells past the slot take the left neighbor, the slot takes the new word
        if (MY_POS > pos) begin
          data_nxt = left_data;
        end else if (MY_POS == pos) begin
          data_nxt = ctl.value;
        end
      end
      ile_pkg::CELL_DEL: begin
        if (MY_POS >= pos) begin
          data_nxt = right_data;
        end
      end
      ile_pkg::CELL_SET: begin
        if (MY_POS == pos) begin
          data_nxt = ctl.value;
        end
      end
      ile_pkg::CELL_RD_LOAD: begin
        rd_nxt = data_r;
      end
      ile_pkg::CELL_RD_SHIFT: begin
        // advance the read line one cell toward cell 0
        rd_nxt = right_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = rd_r;

endmodule

// ===== rtl/core/ile_ctrl.sv =====
module ile_ctrl #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
  parameter int POS_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ile_req_if.sink                      req,
  ile_rsp_if.source                    rsp,
  input  logic [ile_pkg::VAL_W-1:0]    rd0,
  output ile_pkg::cell_ctl_t           ctl,
  output logic [POS_W-1:0]             pos
);

  localparam int CW = (CNT_W > ile_pkg::IDX_W) ? CNT_W : ile_pkg::IDX_W;

  ile_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ok_r, out_ok_nxt;
  logic [ile_pkg::VAL_W-1:0]     out_rd_r, out_rd_nxt;
  logic [ile_pkg::CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                          load_out;

  logic accept, out_free;

  logic               ok_d, rev_d;
  ile_pkg::cell_op_t  op_d;
  logic [CW-1:0]      q_d, n_c, idx_c;
  logic [CNT_W-1:0]   count_d;
  logic               full, empty;

  assign out_free  = !out_valid_r || rsp.ready;
  assign req.ready = (state_r == ile_pkg::ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  // decode the request against the current length and order flag
  always_comb begin
    n_c     = CW'(count_r);
    idx_c   = CW'(req.index);
    full    = (count_r == CNT_W'(CAPACITY));
    empty   = (count_r == '0);
    ok_d    = 1'b0;
    op_d    = ile_pkg::CELL_HOLD;
    q_d     = '0;
    rev_d   = rev_r;
    count_d = count_r;
    case (ile_pkg::req_t'(req.req_type))
      ile_pkg::REQ_APPEND: begin
        ok_d = !full;
        op_d = ile_pkg::CELL_INS;
        q_d  = rev_r ? '0 : n_c;
      end
      ile_pkg::REQ_PREPEND: begin
        ok_d = !full;
        op_d = ile_pkg::CELL_INS;
        q_d  = rev_r ? n_c : '0;
      end
      ile_pkg::REQ_INSERT: begin
        ok_d = !full && (idx_c <= n_c);
        op_d = ile_pkg::CELL_INS;
        q_d  = rev_r ? (n_c - idx_c) : idx_c;
      end
      ile_pkg::REQ_REMOVE_LAST: begin
        ok_d = !empty;
        op_d = ile_pkg::CELL_DEL;
        q_d  = rev_r ? '0 : (n_c - 1'b1);
      end
      ile_pkg::REQ_REMOVE_FIRST: begin
        ok_d = !empty;
        op_d = ile_pkg::CELL_DEL;
        q_d  = rev_r ? (n_c - 1'b1) : '0;
      end
      ile_pkg::REQ_DELETE: begin
        ok_d = (idx_c < n_c);
        op_d = ile_pkg::CELL_DEL;
        q_d  = rev_r ? (n_c - 1'b1 - idx_c) : idx_c;
      end
      ile_pkg::REQ_GET: begin
        ok_d = (idx_c < n_c);
        op_d = ile_pkg::CELL_RD_LOAD;
        q_d  = rev_r ? (n_c - 1'b1 - idx_c) : idx_c;
      end
      ile_pkg::REQ_SET: begin
        ok_d = (idx_c < n_c);
        op_d = ile_pkg::CELL_SET;
        q_d  = rev_r ? (n_c - 1'b1 - idx_c) : idx_c;
      end
      ile_pkg::REQ_REVERSE: begin
        ok_d = 1'b1;
        if (!empty) begin
          rev_d = !rev_r;
        end
      end
      default: begin
      end
    endcase
    if (!ok_d) begin
      op_d  = ile_pkg::CELL_HOLD;
      rev_d = rev_r;
    end else if (op_d == ile_pkg::CELL_INS) begin
      count_d = count_r + 1'b1;
    end else if (op_d == ile_pkg::CELL_DEL) begin
      count_d = count_r - 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ile_pkg::ST_IDLE: begin
        if (accept && (op_d == ile_pkg::CELL_RD_LOAD)) begin
          state_nxt = ile_pkg::ST_READ;
        end
      end
      ile_pkg::ST_READ: begin
        if ((cnt_r == '0) && out_free) begin
          state_nxt = ile_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ile_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl.op      = ile_pkg::CELL_HOLD;
    ctl.value   = req.value;
    pos         = q_d[POS_W-1:0];
    load_out    = 1'b0;
    out_ok_nxt  = out_ok_r;
    out_rd_nxt  = out_rd_r;
    out_cnt_nxt = out_cnt_r;
    cnt_nxt     = cnt_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    case (state_r)
      ile_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.op    = op_d;
          count_nxt = count_d;
          rev_nxt   = rev_d;
          if (op_d == ile_pkg::CELL_RD_LOAD) begin
            cnt_nxt = q_d[POS_W-1:0];
          end else begin
            load_out    = 1'b1;
            out_ok_nxt  = ok_d;
            out_rd_nxt  = '0;
            out_cnt_nxt = ile_pkg::CNT_OUT_W'(count_d);
          end
        end
      end
      ile_pkg::ST_READ: begin
        if (cnt_r == '0) begin
          if (out_free) begin
            load_out    = 1'b1;
            out_ok_nxt  = 1'b1;
            out_rd_nxt  = rd0;
            out_cnt_nxt = ile_pkg::CNT_OUT_W'(count_r);
          end
        end else begin
          ctl.op  = ile_pkg::CELL_RD_SHIFT;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ile_pkg::ST_IDLE;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    out_ok_r  <= out_ok_nxt;
    out_rd_r  <= out_rd_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign rsp.valid      = out_valid_r;
  assign rsp.ok         = out_ok_r;
  assign rsp.read_value = out_rd_r;
  assign rsp.count      = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op_d == ile_pkg::CELL_INS) |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the list by one");

  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !ok_d |=> $stable(count_r) && $stable(rev_r))
    else $error("rejected request changed the list");

  a_read_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::ST_READ) && (cnt_r != '0) |=>
      (state_r == ile_pkg::ST_READ) && (cnt_r == POS_W'($past(cnt_r) - 1'b1)))
    else $error("read walk did not advance");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::ST_READ) && (cnt_r == '0) && out_free |=> out_valid_r && out_ok_r)
    else $error("read finished without a result word");

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Results: a request other than a successful get shows its result word in the cycle
//   after acceptance; a successful get of physical cell p loads the read line, then
//   shifts it toward cell 0, one cell per step, until that word sits in cell 0.
// Throughput: one request per cycle while no result word waits; a successful get holds
//   off the next request while it walks. Reverse only flips an order flag.
// Reset (rst_n low, synchronous): empty list, forward order, no result pending.
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ile_req_if.sink     in_chan,
  ile_rsp_if.source   out_chan
);

  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  ile_pkg::cell_ctl_t         ctl;
  logic [POS_W-1:0]           pos;
  logic [ile_pkg::VAL_W-1:0]  data_w  [CAPACITY];
  logic [ile_pkg::VAL_W-1:0]  rd_w    [CAPACITY];
  logic [ile_pkg::VAL_W-1:0]  left_w  [CAPACITY];
  logic [ile_pkg::VAL_W-1:0]  right_w [CAPACITY];
  logic [ile_pkg::VAL_W-1:0]  rdin_w  [CAPACITY];

  ile_ctrl #(
    .CAPACITY (CAPACITY),
    .POS_W    (POS_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_chan),
    .rsp   (out_chan),
    .rd0   (rd_w[0]),
    .ctl   (ctl),
    .pos   (pos)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left_w[j] = '0;
    end else begin : g_link_l
      assign left_w[j] = data_w[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign right_w[j] = '0;
      assign rdin_w[j]  = '0;
    end else begin : g_link_r
      assign right_w[j] = data_w[j+1];
      assign rdin_w[j]  = rd_w[j+1];
    end

    ile_cell #(
      .POS_W (POS_W),
      .J     (j)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .left_data  (left_w[j]),
      .right_data (right_w[j]),
      .right_rd   (rdin_w[j]),
      .data_o     (data_w[j]),
      .rd_o       (rd_w[j])
    );
  end

endmodule
